// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the RTL of the shader output clamp rewriter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is held.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/socr_pkg.sv =====
// ----------------------------------------------------------------------------
// socr_pkg
// Types, opcodes and sizes shared by the shader output clamp rewriter.
// ----------------------------------------------------------------------------
package socr_pkg;

  localparam int PTR_SLOTS = 8;
  localparam int VAR_SLOTS = 16;
  localparam int PTR_CW = $clog2(PTR_SLOTS + 1);
  localparam int VAR_CW = $clog2(VAR_SLOTS + 1);
  localparam int PTR_IW = (PTR_SLOTS > 1) ? $clog2(PTR_SLOTS) : 1;
  localparam int VAR_IW = (VAR_SLOTS > 1) ? $clog2(VAR_SLOTS) : 1;

  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int Q_CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] MAGIC_WORD = 32'h0723_0203;
  localparam logic [31:0] FLOAT_ONE  = 32'h3F80_0000;
  localparam logic [31:0] GLSL_W0    = 32'h4C53_4C47;
  localparam logic [31:0] GLSL_W1    = 32'h6474_732E;
  localparam logic [31:0] GLSL_W2    = 32'h3035_342E;
  localparam logic [31:0] NCLAMP_INST = 32'd81;
  localparam logic [31:0] STORAGE_OUTPUT = 32'd3;
  localparam logic [31:0] ALPHA_LANE = 32'd3;

  localparam logic [15:0] OP_EXT_IMPORT      = 16'd11;
  localparam logic [15:0] OP_EXT_INST        = 16'd12;
  localparam logic [15:0] OP_TYPE_FLOAT      = 16'd22;
  localparam logic [15:0] OP_TYPE_VECTOR     = 16'd23;
  localparam logic [15:0] OP_TYPE_POINTER    = 16'd32;
  localparam logic [15:0] OP_CONSTANT        = 16'd43;
  localparam logic [15:0] OP_CONST_COMPOSITE = 16'd44;
  localparam logic [15:0] OP_FUNCTION        = 16'd54;
  localparam logic [15:0] OP_VARIABLE        = 16'd59;
  localparam logic [15:0] OP_STORE           = 16'd62;
  localparam logic [15:0] OP_EXTRACT         = 16'd81;
  localparam logic [15:0] OP_INSERT          = 16'd82;

  localparam logic [2:0] ST_DATA     = 3'd0;
  localparam logic [2:0] ST_OK       = 3'd1;
  localparam logic [2:0] ST_BAD_HDR  = 3'd2;
  localparam logic [2:0] ST_MALFORM  = 3'd3;
  localparam logic [2:0] ST_NOTHING  = 3'd4;
  localparam logic [2:0] ST_OVERFLOW = 3'd5;

  localparam logic [2:0] FLAG_BAD  = 3'b001;
  localparam logic [2:0] FLAG_MAL  = 3'b010;
  localparam logic [2:0] FLAG_OVF  = 3'b100;

  localparam logic OPSEL_LEARN = 1'b0;

  // One command from the front part: the beats one input word causes.
  typedef struct packed {
    logic [3:0]       cmask;   // constants to insert, scalar 0/1, vec4 0/1
    logic             pre;     // held store word 0 before the word
    logic             word;    // the (maybe patched) word itself
    logic             clamp;   // clamp sequence and rewritten store
    logic [1:0]       fcnt;    // held words flushed at the end of a pass
    logic             stat;    // learning status beat
    logic             last;
    logic             alpha;
    logic [2:0]       status;
    logic [31:0]      wv;
    logic [31:0]      h0;
    logic [31:0]      h1;
    logic [31:0]      cbase;
    logic [31:0]      fid;
    logic [31:0]      vid;
    logic [31:0]      eid;
    logic [3:0][31:0] cid;
  } socr_desc_t;

  typedef enum logic [5:0] {
    PH_CONST = 6'b000001,
    PH_PRE   = 6'b000010,
    PH_WORD  = 6'b000100,
    PH_CLAMP = 6'b001000,
    PH_FLUSH = 6'b010000,
    PH_STAT  = 6'b100000
  } socr_phase_t;

endpackage

// ===== rtl/socr_front.sv =====
// ----------------------------------------------------------------------------
// socr_front
// Accepts module words, tracks instruction boundaries, keeps the learned
// tables and issues one command per word that causes beats.
// ----------------------------------------------------------------------------
module socr_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic [31:0]         in_word,
  input  logic                in_last,
  input  logic                cfg_valid,
  input  logic                cfg_alpha_only_mode,
  input  logic                q_full,
  output logic                push,
  output socr_pkg::socr_desc_t push_desc
);

  logic [31:0] word_index_r, word_index_nxt;
  logic [15:0] pos_r, pos_nxt, len_r, len_nxt, opc_r, opc_nxt;
  logic [31:0] s0_r, s0_nxt, s2_r, s2_nxt;
  logic        s1_r, s1_nxt;
  logic [31:0] ext_r, ext_nxt, flt_r, flt_nxt, vec_r, vec_nxt;
  logic [3:0][31:0] cid_r, cid_nxt;
  logic [socr_pkg::PTR_SLOTS-1:0][31:0] ptab_r, ptab_nxt;
  logic [socr_pkg::VAR_SLOTS-1:0][31:0] vtab_r, vtab_nxt;
  logic [socr_pkg::PTR_CW-1:0] pcnt_r, pcnt_nxt;
  logic [socr_pkg::VAR_CW-1:0] vcnt_r, vcnt_nxt;
  logic        fn_r, fn_nxt;
  logic [31:0] sc_r, sc_nxt, bound_r, bound_nxt;
  logic [31:0] h0_r, h0_nxt, h1_r, h1_nxt;
  logic [2:0]  lstat_r, lstat_nxt, flags_r, flags_nxt;
  logic [3:0]  mint_r, mint_nxt;
  logic [1:0]  held_r, held_nxt;
  logic        ins_r, ins_nxt;
  logic [31:0] nid_r, nid_nxt;
  logic        alpha_r;
  logic        accept;
  socr_pkg::socr_desc_t d;

  function automatic logic ptr_hit(input logic [socr_pkg::PTR_SLOTS-1:0][31:0] t,
                                   input logic [socr_pkg::PTR_CW-1:0] n,
                                   input logic [31:0] v);
    logic h;
    h = 1'b0;
    for (int i = 0; i < socr_pkg::PTR_SLOTS; i++) begin
      if (socr_pkg::PTR_CW'(i) < n && t[i] == v) h = 1'b1;
    end
    return h;
  endfunction

  function automatic logic var_hit(input logic [socr_pkg::VAR_SLOTS-1:0][31:0] t,
                                   input logic [socr_pkg::VAR_CW-1:0] n,
                                   input logic [31:0] v);
    logic h;
    h = 1'b0;
    for (int i = 0; i < socr_pkg::VAR_SLOTS; i++) begin
      if (socr_pkg::VAR_CW'(i) < n && t[i] == v) h = 1'b1;
    end
    return h;
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    logic [15:0] p;
    logic [15:0] nl;
    logic        learned;
    logic        adv;
    logic [2:0]  st;
    word_index_nxt = word_index_r;
    pos_nxt = pos_r; len_nxt = len_r; opc_nxt = opc_r;
    s0_nxt = s0_r; s1_nxt = s1_r; s2_nxt = s2_r;
    ext_nxt = ext_r; flt_nxt = flt_r; vec_nxt = vec_r; cid_nxt = cid_r;
    ptab_nxt = ptab_r; vtab_nxt = vtab_r; pcnt_nxt = pcnt_r; vcnt_nxt = vcnt_r;
    fn_nxt = fn_r; sc_nxt = sc_r; bound_nxt = bound_r;
    h0_nxt = h0_r; h1_nxt = h1_r;
    lstat_nxt = lstat_r; flags_nxt = flags_r; mint_nxt = mint_r;
    held_nxt = held_r; ins_nxt = ins_r; nid_nxt = nid_r;
    d = '0;
    p = pos_r;
    nl = in_word[31:16];
    learned = (lstat_r == socr_pkg::ST_OK);
    adv = 1'b0;
    st = socr_pkg::ST_OK;

    if (in_op == socr_pkg::OPSEL_LEARN) begin
      if (word_index_r == 32'd0) begin
        ext_nxt = '0; flt_nxt = '0; vec_nxt = '0; cid_nxt = '0;
        pcnt_nxt = '0; vcnt_nxt = '0; fn_nxt = 1'b0; sc_nxt = '0; bound_nxt = '0;
        lstat_nxt = '0; flags_nxt = '0; mint_nxt = '0; pos_nxt = '0;
        if (in_word != socr_pkg::MAGIC_WORD) flags_nxt = flags_nxt | socr_pkg::FLAG_BAD;
      end
      if (word_index_r == 32'd3) bound_nxt = in_word;
      if (word_index_r >= 32'd5 &&
          (flags_nxt & (socr_pkg::FLAG_BAD | socr_pkg::FLAG_MAL)) == 3'd0) begin
        p = pos_nxt;
        if (p == 16'd0) begin
          if (nl == 16'd0) begin
            flags_nxt = flags_nxt | socr_pkg::FLAG_MAL;
          end else begin
            len_nxt = nl;
            opc_nxt = in_word[15:0];
            if (opc_nxt == socr_pkg::OP_FUNCTION) fn_nxt = 1'b1;
            s0_nxt = '0; s1_nxt = 1'b0; s2_nxt = '0;
            adv = 1'b1;
          end
        end else begin
          adv = 1'b1;
          if (p == 16'd1) s0_nxt = in_word;
          case (opc_nxt)
            socr_pkg::OP_EXT_IMPORT: begin
              if (p == 16'd2) s1_nxt = (in_word == socr_pkg::GLSL_W0);
              if (p == 16'd3) s1_nxt = s1_nxt && (in_word == socr_pkg::GLSL_W1);
              if (p == 16'd4) begin
                s1_nxt = s1_nxt && (in_word == socr_pkg::GLSL_W2);
                if (len_nxt == 16'd5 && s1_nxt) ext_nxt = s0_nxt;
              end
              if (p == 16'd5 && s1_nxt && in_word[7:0] == 8'd0) ext_nxt = s0_nxt;
            end
            socr_pkg::OP_TYPE_FLOAT: begin
              if (len_nxt == 16'd3 && p == 16'd2 && in_word == 32'd32) flt_nxt = s0_nxt;
            end
            socr_pkg::OP_TYPE_VECTOR: begin
              if (len_nxt == 16'd4) begin
                if (p == 16'd2) s1_nxt = (flt_nxt != '0 && in_word == flt_nxt);
                if (p == 16'd3 && s1_nxt && in_word == 32'd4) vec_nxt = s0_nxt;
              end
            end
            socr_pkg::OP_TYPE_POINTER: begin
              if (len_nxt == 16'd4) begin
                if (p == 16'd2) s1_nxt = (in_word == socr_pkg::STORAGE_OUTPUT);
                if (p == 16'd3 && s1_nxt && vec_nxt != '0 && in_word == vec_nxt &&
                    !ptr_hit(ptab_nxt, pcnt_nxt, s0_nxt)) begin
                  if (pcnt_nxt >= socr_pkg::PTR_CW'(socr_pkg::PTR_SLOTS)) begin
                    flags_nxt = flags_nxt | socr_pkg::FLAG_OVF;
                  end else begin
                    ptab_nxt[pcnt_nxt[socr_pkg::PTR_IW-1:0]] = s0_nxt;
                    pcnt_nxt = pcnt_nxt + 1'b1;
                  end
                end
              end
            end
            socr_pkg::OP_CONSTANT: begin
              if (len_nxt == 16'd4) begin
                if (p == 16'd1) s1_nxt = (flt_nxt != '0 && in_word == flt_nxt);
                if (p == 16'd2) s0_nxt = in_word;
                if (p == 16'd3 && s1_nxt) begin
                  if (in_word == 32'd0) cid_nxt[0] = s0_nxt;
                  if (in_word == socr_pkg::FLOAT_ONE) cid_nxt[1] = s0_nxt;
                end
              end
            end
            socr_pkg::OP_CONST_COMPOSITE: begin
              if (len_nxt == 16'd7) begin
                if (p == 16'd1) s1_nxt = (vec_nxt != '0 && in_word == vec_nxt);
                if (p == 16'd2) s0_nxt = in_word;
                if (p == 16'd3) s2_nxt = in_word;
                if (p >= 16'd4) s1_nxt = s1_nxt && (in_word == s2_nxt);
                if (p == 16'd6 && s1_nxt) begin
                  if (cid_nxt[0] != '0 && s2_nxt == cid_nxt[0]) cid_nxt[2] = s0_nxt;
                  if (cid_nxt[1] != '0 && s2_nxt == cid_nxt[1]) cid_nxt[3] = s0_nxt;
                end
              end
            end
            socr_pkg::OP_VARIABLE: begin
              if (len_nxt >= 16'd4) begin
                if (p == 16'd1) s1_nxt = ptr_hit(ptab_nxt, pcnt_nxt, in_word);
                if (p == 16'd2) s0_nxt = in_word;
                if (p == 16'd3 && s1_nxt && in_word == socr_pkg::STORAGE_OUTPUT &&
                    !var_hit(vtab_nxt, vcnt_nxt, s0_nxt)) begin
                  if (vcnt_nxt >= socr_pkg::VAR_CW'(socr_pkg::VAR_SLOTS)) begin
                    flags_nxt = flags_nxt | socr_pkg::FLAG_OVF;
                  end else begin
                    vtab_nxt[vcnt_nxt[socr_pkg::VAR_IW-1:0]] = s0_nxt;
                    vcnt_nxt = vcnt_nxt + 1'b1;
                  end
                end
              end
            end
            socr_pkg::OP_STORE: begin
              if (len_nxt >= 16'd3 && p == 16'd1 && var_hit(vtab_nxt, vcnt_nxt, in_word))
                sc_nxt = sc_nxt + 32'd1;
            end
            default: begin
            end
          endcase
        end
      end
      if (adv) begin
        pos_nxt = p + 16'd1;
        if (pos_nxt >= len_nxt) pos_nxt = '0;
      end
      if (in_last) begin
        if (word_index_r < 32'd4 || (flags_nxt & socr_pkg::FLAG_BAD) != 3'd0) begin
          st = socr_pkg::ST_BAD_HDR;
        end else if ((flags_nxt & socr_pkg::FLAG_MAL) != 3'd0 || pos_nxt != 16'd0) begin
          st = socr_pkg::ST_MALFORM;
        end else if ((flags_nxt & socr_pkg::FLAG_OVF) != 3'd0) begin
          st = socr_pkg::ST_OVERFLOW;
        end else if (ext_nxt == '0 || vec_nxt == '0 || vcnt_nxt == '0 || !fn_nxt) begin
          st = socr_pkg::ST_NOTHING;
        end else begin
          st = socr_pkg::ST_OK;
          // Missing constants take fresh ids from the bound, in fixed order.
          for (int k = 0; k < 4; k++) begin
            if (cid_nxt[k] == '0) begin
              cid_nxt[k] = bound_nxt;
              bound_nxt = bound_nxt + 32'd1;
              mint_nxt[k] = 1'b1;
            end
          end
        end
        lstat_nxt = st;
        d.stat = 1'b1;
        d.status = st;
      end
    end else begin
      if (word_index_r == 32'd0) begin
        held_nxt = '0; ins_nxt = 1'b0; nid_nxt = bound_r; pos_nxt = '0;
      end
      p = pos_nxt;
      if (word_index_r < 32'd5) begin
        d.word = 1'b1;
        if (word_index_r == 32'd3 && learned)
          d.wv = alpha_r ? (bound_r + sc_r + {sc_r[30:0], 1'b0}) : (bound_r + sc_r);
        else
          d.wv = in_word;
      end else begin
        adv = 1'b1;
        if (p == 16'd0) begin
          len_nxt = (nl == 16'd0) ? 16'd1 : nl;
          opc_nxt = in_word[15:0];
          if (learned && opc_nxt == socr_pkg::OP_FUNCTION && !ins_nxt) begin
            d.cmask = mint_r;
            ins_nxt = 1'b1;
          end
          if (learned && opc_nxt == socr_pkg::OP_STORE && len_nxt >= 16'd3) begin
            h0_nxt = in_word;
            held_nxt = 2'd1;
          end else begin
            d.word = 1'b1;
            d.wv = in_word;
          end
        end else if (held_nxt == 2'd1 && p == 16'd1) begin
          if (var_hit(vtab_r, vcnt_r, in_word)) begin
            h1_nxt = in_word;
            held_nxt = 2'd2;
          end else begin
            d.pre = 1'b1;
            d.word = 1'b1;
            d.wv = in_word;
            held_nxt = '0;
          end
        end else if (held_nxt == 2'd2 && p == 16'd2) begin
          d.clamp = 1'b1;
          d.wv = in_word;
          d.cbase = nid_nxt;
          nid_nxt = nid_nxt + (alpha_r ? 32'd3 : 32'd1);
          held_nxt = '0;
        end else begin
          d.word = 1'b1;
          d.wv = in_word;
        end
      end
      if (adv) begin
        pos_nxt = p + 16'd1;
        if (pos_nxt >= len_nxt) pos_nxt = '0;
      end
      if (in_last) begin
        d.fcnt = held_nxt;
        held_nxt = '0;
      end
    end

    if (in_last) begin
      word_index_nxt = '0;
      pos_nxt = '0;
    end else if (word_index_r != 32'hFFFF_FFFF) begin
      word_index_nxt = word_index_r + 32'd1;
    end

    d.last  = in_last;
    d.alpha = alpha_r;
    d.h0    = h0_nxt;
    d.h1    = h1_nxt;
    d.fid   = flt_nxt;
    d.vid   = vec_nxt;
    d.eid   = ext_nxt;
    d.cid   = cid_nxt;
  end

  assign push_desc = d;
  assign push = accept &&
                (d.cmask != 4'd0 || d.pre || d.word || d.clamp || d.fcnt != 2'd0 || d.stat);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= 1'b0;
    end else if (cfg_valid) begin
      alpha_r <= cfg_alpha_only_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_index_r <= '0; pos_r <= '0; len_r <= '0; opc_r <= '0;
      s0_r <= '0; s1_r <= 1'b0; s2_r <= '0;
      ext_r <= '0; flt_r <= '0; vec_r <= '0; cid_r <= '0;
      pcnt_r <= '0; vcnt_r <= '0; fn_r <= 1'b0; sc_r <= '0; bound_r <= '0;
      h0_r <= '0; h1_r <= '0; lstat_r <= '0; flags_r <= '0; mint_r <= '0;
      held_r <= '0; ins_r <= 1'b0; nid_r <= '0;
    end else if (accept) begin
      word_index_r <= word_index_nxt; pos_r <= pos_nxt; len_r <= len_nxt;
      opc_r <= opc_nxt; s0_r <= s0_nxt; s1_r <= s1_nxt; s2_r <= s2_nxt;
      ext_r <= ext_nxt; flt_r <= flt_nxt; vec_r <= vec_nxt; cid_r <= cid_nxt;
      pcnt_r <= pcnt_nxt; vcnt_r <= vcnt_nxt; fn_r <= fn_nxt; sc_r <= sc_nxt;
      bound_r <= bound_nxt; h0_r <= h0_nxt; h1_r <= h1_nxt; lstat_r <= lstat_nxt;
      flags_r <= flags_nxt; mint_r <= mint_nxt; held_r <= held_nxt; ins_r <= ins_nxt;
      nid_r <= nid_nxt;
    end
  end

  // The tables are only read below their fill counts.
  always_ff @(posedge clk) begin
    if (accept) begin
      ptab_r <= ptab_nxt;
      vtab_r <= vtab_nxt;
    end
  end

endmodule

// ===== rtl/socr_queue.sv =====
// ----------------------------------------------------------------------------
// socr_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module socr_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  socr_pkg::socr_desc_t push_desc,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output socr_pkg::socr_desc_t head
);

  socr_pkg::socr_desc_t mem_r [socr_pkg::QUEUE_DEPTH];
  logic [socr_pkg::Q_PW-1:0] wr_r, rd_r;
  logic [socr_pkg::Q_CW-1:0] cnt_r;
  logic do_push, do_pop;

  assign full       = (cnt_r == socr_pkg::Q_CW'(socr_pkg::QUEUE_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r <= '0;
      rd_r <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push)
        wr_r <= (wr_r == socr_pkg::Q_PW'(socr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (do_pop)
        rd_r <= (rd_r == socr_pkg::Q_PW'(socr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_desc;
  end

endmodule

// ===== rtl/socr_back.sv =====
// ----------------------------------------------------------------------------
// socr_back
// Expands queued commands into output beats, one beat per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module socr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 head_valid,
  input  socr_pkg::socr_desc_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [31:0]          out_word,
  output logic                 out_run_last,
  output logic                 out_module_end,
  output logic [2:0]           out_status
);

  logic                  busy_r, busy_nxt;
  socr_pkg::socr_phase_t phase_r, phase_nxt, cur;
  logic [1:0]            k_r, k_nxt, cur_k, first_k, hi_k;
  logic [4:0]            j_r, j_nxt, cj;
  logic [5:0]            pv, first, later, nextp;
  logic [3:0]            higher;
  logic                  phase_end, desc_end, adv;
  logic [31:0]           bw;
  logic                  ov_r;
  logic [31:0]           ow_r;
  logic                  orl_r, ome_r;
  logic [2:0]            ost_r;

  assign pv = {head.stat, head.fcnt != 2'd0, head.clamp, head.word, head.pre,
               head.cmask != 4'd0};
  assign first = pv & (~pv + 6'd1);

  always_comb begin
    first_k = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (head.cmask[i]) first_k = 2'(i);
    end
  end

  assign cur   = busy_r ? phase_r : socr_pkg::socr_phase_t'(first);
  assign cur_k = busy_r ? k_r : first_k;
  assign cj    = busy_r ? j_r : 5'd0;

  always_comb begin
    higher = head.cmask & ~((4'd2 << cur_k) - 4'd1);
    hi_k = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (higher[i]) hi_k = 2'(i);
    end
  end

  always_comb begin
    logic [31:0] a, ca;
    a  = head.cbase + 32'd1;
    ca = head.cbase + 32'd2;
    bw = '0;
    phase_end = 1'b1;
    unique case (cur)
      socr_pkg::PH_CONST: begin
        if (!cur_k[1]) begin
          case (cj)
            5'd0:    bw = {16'd4, socr_pkg::OP_CONSTANT};
            5'd1:    bw = head.fid;
            5'd2:    bw = head.cid[cur_k];
            default: bw = cur_k[0] ? socr_pkg::FLOAT_ONE : 32'd0;
          endcase
          phase_end = (cj == 5'd3) && (higher == 4'd0);
        end else begin
          case (cj)
            5'd0:    bw = {16'd7, socr_pkg::OP_CONST_COMPOSITE};
            5'd1:    bw = head.vid;
            5'd2:    bw = head.cid[cur_k];
            default: bw = head.cid[{1'b0, cur_k[0]}];
          endcase
          phase_end = (cj == 5'd6) && (higher == 4'd0);
        end
      end
      socr_pkg::PH_PRE:  bw = head.h0;
      socr_pkg::PH_WORD: bw = head.wv;
      socr_pkg::PH_CLAMP: begin
        if (head.alpha) begin
          case (cj)
            5'd0:  bw = {16'd5, socr_pkg::OP_EXTRACT};
            5'd1:  bw = head.fid;
            5'd2:  bw = a;
            5'd3:  bw = head.wv;
            5'd4:  bw = socr_pkg::ALPHA_LANE;
            5'd5:  bw = {16'd8, socr_pkg::OP_EXT_INST};
            5'd6:  bw = head.fid;
            5'd7:  bw = ca;
            5'd8:  bw = head.eid;
            5'd9:  bw = socr_pkg::NCLAMP_INST;
            5'd10: bw = a;
            5'd11: bw = head.cid[0];
            5'd12: bw = head.cid[1];
            5'd13: bw = {16'd6, socr_pkg::OP_INSERT};
            5'd14: bw = head.vid;
            5'd15: bw = head.cbase;
            5'd16: bw = ca;
            5'd17: bw = head.wv;
            5'd18: bw = socr_pkg::ALPHA_LANE;
            5'd19: bw = head.h0;
            5'd20: bw = head.h1;
            default: bw = head.cbase;
          endcase
          phase_end = (cj == 5'd21);
        end else begin
          case (cj)
            5'd0:  bw = {16'd8, socr_pkg::OP_EXT_INST};
            5'd1:  bw = head.vid;
            5'd2:  bw = head.cbase;
            5'd3:  bw = head.eid;
            5'd4:  bw = socr_pkg::NCLAMP_INST;
            5'd5:  bw = head.wv;
            5'd6:  bw = head.cid[2];
            5'd7:  bw = head.cid[3];
            5'd8:  bw = head.h0;
            5'd9:  bw = head.h1;
            default: bw = head.cbase;
          endcase
          phase_end = (cj == 5'd10);
        end
      end
      socr_pkg::PH_FLUSH: begin
        bw = (cj == 5'd0) ? head.h0 : head.h1;
        phase_end = ({3'd0, head.fcnt} == cj + 5'd1);
      end
      socr_pkg::PH_STAT: bw = 32'd0;
      default: bw = '0;
    endcase
  end

  assign later    = pv & ~(cur | (cur - 6'd1));
  assign nextp    = later & (~later + 6'd1);
  assign desc_end = phase_end && (later == 6'd0);
  assign adv      = head_valid && (!ov_r || out_ready);
  assign pop      = adv && desc_end;

  always_comb begin
    busy_nxt  = busy_r;
    phase_nxt = phase_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    if (adv) begin
      if (desc_end) begin
        busy_nxt = 1'b0;
      end else begin
        busy_nxt = 1'b1;
        if (phase_end) begin
          phase_nxt = socr_pkg::socr_phase_t'(nextp);
          j_nxt = '0;
          k_nxt = cur_k;
        end else if (cur == socr_pkg::PH_CONST &&
                     ((!cur_k[1] && cj == 5'd3) || (cur_k[1] && cj == 5'd6))) begin
          phase_nxt = cur;
          k_nxt = hi_k;
          j_nxt = '0;
        end else begin
          phase_nxt = cur;
          k_nxt = cur_k;
          j_nxt = cj + 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= socr_pkg::PH_CONST;
      k_r     <= '0;
      j_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      phase_r <= phase_nxt;
      k_r     <= k_nxt;
      j_r     <= j_nxt;
      if (adv) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ow_r  <= bw;
      orl_r <= desc_end;
      ome_r <= desc_end && head.last;
      ost_r <= (cur == socr_pkg::PH_STAT) ? head.status : socr_pkg::ST_DATA;
    end
  end

  assign out_valid      = ov_r;
  assign out_word       = ow_r;
  assign out_run_last   = orl_r;
  assign out_module_end = ome_r;
  assign out_status     = ost_r;

endmodule

// ===== rtl/shader_output_clamp_rewriter_unit.sv =====
// ----------------------------------------------------------------------------
// shader_output_clamp_rewriter_unit
// Learns the output variables of a shader module in a first pass and, in a
// second pass, rewrites every output store through a clamp to [0,1].
// ----------------------------------------------------------------------------
//
//   channel   direction  ports                                      beat
//   in        input      in_valid/in_ready, in_op, in_word, in_last one module word
//   out       output     out_valid/out_ready, out_word, out_run_last,
//                        out_module_end, out_status                 one result word
//   cfg       input      cfg_valid/cfg_ready, cfg_alpha_only_mode   mode register write
//
// The front part takes one input beat per cycle while the command queue has
// room; it updates all learned state in that cycle. The back part sends one
// output beat per cycle while the output is not stalled. A constant
// insertion or a clamped store expands into up to 23 beats and holds the
// input back while they drain once the queue fills. Reset (rst_n low at a
// clock edge) clears all control and learned state; no clearing pass is run.
// Either channel may stall at will; the output register decouples them.
//
module shader_output_clamp_rewriter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [31:0] in_word,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word,
  output logic        out_run_last,
  output logic        out_module_end,
  output logic [2:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_alpha_only_mode
);

  `include "assert_macros.svh"

  socr_pkg::socr_desc_t push_desc, head;
  logic push, q_full, pop, head_valid;

  // The mode register is always writable.
  assign cfg_ready = 1'b1;

  // Front: parses words, keeps the learned tables, issues commands.
  socr_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_op               (in_op),
    .in_word             (in_word),
    .in_last             (in_last),
    .cfg_valid           (cfg_valid),
    .cfg_alpha_only_mode (cfg_alpha_only_mode),
    .q_full              (q_full),
    .push                (push),
    .push_desc           (push_desc)
  );

  // Command queue: lets the front run ahead while a burst drains.
  socr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back: turns each command into its beats.
  socr_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_word       (out_word),
    .out_run_last   (out_run_last),
    .out_module_end (out_module_end),
    .out_status     (out_status)
  );

  // The end of a pass is always the last beat of its input word.
  `ASSERT_CLK(a_end_is_run_last, out_valid && out_module_end |-> out_run_last, "module end without run last")
  // A status beat only ever closes a learning pass.
  `ASSERT_CLK(a_status_closes, out_valid && out_status != socr_pkg::ST_DATA |-> out_module_end && out_word == 32'd0, "status beat not at pass end")
  // The front never pushes into a full queue.
  `ASSERT_CLK(a_no_overrun, q_full |-> !(in_valid && in_ready), "input taken with full queue")

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the shader output clamp rewriter. Shader modules are
// streamed in learning/rewrite pass pairs with random content, checked beat by
// beat against a behavioral predictor, under random input gaps and output
// stalls, including one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import socr_pkg::*;

  // One pending input beat.
  typedef struct {
    logic        op;
    logic [31:0] w;
    logic        last;
  } word_beat_t;

  typedef struct {
    logic [31:0] w;
    logic        run_last;
    logic        mod_end;
    logic [2:0]  st;
  } result_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_op = 1'b0;
  logic [31:0] in_word = '0;
  logic        in_last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_word;
  logic        out_run_last;
  logic        out_module_end;
  logic [2:0]  out_status;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_alpha_only_mode = 1'b0;

  shader_output_clamp_rewriter_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op), .in_word(in_word),
    .in_last(in_last),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word),
    .out_run_last(out_run_last), .out_module_end(out_module_end),
    .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_alpha_only_mode(cfg_alpha_only_mode)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: a copy of everything the block learns and tracks.
  // ---------------------------------------------------------------------------
  logic        mode_alpha;
  logic [31:0] widx;
  logic [15:0] ipos, ilen, iop;
  logic [31:0] scr [3];
  logic [31:0] ext_id, flt_id, vec_id;
  logic [31:0] cids [4];
  logic [31:0] ptr_tab [PTR_SLOTS];
  int          ptr_cnt;
  logic [31:0] var_tab [VAR_SLOTS];
  int          var_cnt;
  logic        fn_seen;
  logic [31:0] stores, bound;
  logic [31:0] held [2];
  logic [2:0]  lstat, lflags;
  logic [3:0]  minted;
  int          held_n;
  logic        consts_done;
  logic [31:0] free_id;

  result_beat_t expected_beats[$];
  result_beat_t step_beats[$];
  word_beat_t   pending_words[$];

  int  errors = 0;
  int  mismatches = 0;
  longint cycles = 0;

  task automatic put_word(input logic [31:0] w, input logic [2:0] st = ST_DATA);
    result_beat_t b;
    if (step_beats.size() >= 23) return;
    b.w = w; b.run_last = 1'b0; b.mod_end = 1'b0; b.st = st;
    step_beats.insert(step_beats.size(), b);
  endtask

  function automatic bit in_ptrs(input logic [31:0] v);
    for (int i = 0; i < ptr_cnt; i++) if (ptr_tab[i] == v) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit in_vars(input logic [31:0] v);
    for (int i = 0; i < var_cnt; i++) if (var_tab[i] == v) return 1'b1;
    return 1'b0;
  endfunction

  task automatic bump_pos();
    ipos = ipos + 16'd1;
    if (ipos >= ilen) ipos = '0;
  endtask

  task automatic learn_one(input logic [31:0] w);
    logic [15:0] p;
    p = ipos;
    if (p == 0) begin
      if (w[31:16] == 0) begin
        lflags |= FLAG_MAL;
        return;
      end
      ilen = w[31:16];
      iop = w[15:0];
      if (iop == OP_FUNCTION) fn_seen = 1'b1;
      scr[0] = '0; scr[1] = '0; scr[2] = '0;
      bump_pos();
      return;
    end
    if (p == 1) scr[0] = w;
    case (iop)
      OP_EXT_IMPORT: begin
        if (p == 2) scr[1] = 32'(w == GLSL_W0);
        if (p == 3) scr[1] = 32'(scr[1] != 0 && w == GLSL_W1);
        if (p == 4) begin
          scr[1] = 32'(scr[1] != 0 && w == GLSL_W2);
          if (ilen == 5 && scr[1] != 0) ext_id = scr[0];
        end
        if (p == 5 && scr[1] != 0 && w[7:0] == 0) ext_id = scr[0];
      end
      OP_TYPE_FLOAT:
        if (ilen == 3 && p == 2 && w == 32) flt_id = scr[0];
      OP_TYPE_VECTOR:
        if (ilen == 4) begin
          if (p == 2) scr[1] = 32'(flt_id != 0 && w == flt_id);
          if (p == 3 && scr[1] != 0 && w == 4) vec_id = scr[0];
        end
      OP_TYPE_POINTER:
        if (ilen == 4) begin
          if (p == 2) scr[1] = 32'(w == STORAGE_OUTPUT);
          if (p == 3 && scr[1] != 0 && vec_id != 0 && w == vec_id && !in_ptrs(scr[0])) begin
            if (ptr_cnt >= PTR_SLOTS) lflags |= FLAG_OVF;
            else begin
              ptr_tab[ptr_cnt] = scr[0];
              ptr_cnt++;
            end
          end
        end
      OP_CONSTANT:
        if (ilen == 4) begin
          if (p == 1) scr[1] = 32'(flt_id != 0 && w == flt_id);
          if (p == 2) scr[0] = w;
          if (p == 3 && scr[1] != 0) begin
            if (w == 0) cids[0] = scr[0];
            if (w == FLOAT_ONE) cids[1] = scr[0];
          end
        end
      OP_CONST_COMPOSITE:
        if (ilen == 7) begin
          if (p == 1) scr[1] = 32'(vec_id != 0 && w == vec_id);
          if (p == 2) scr[0] = w;
          if (p == 3) scr[2] = w;
          if (p >= 4) scr[1] = 32'(scr[1] != 0 && w == scr[2]);
          if (p == 6 && scr[1] != 0) begin
            if (cids[0] != 0 && scr[2] == cids[0]) cids[2] = scr[0];
            if (cids[1] != 0 && scr[2] == cids[1]) cids[3] = scr[0];
          end
        end
      OP_VARIABLE:
        if (ilen >= 4) begin
          if (p == 1) scr[1] = 32'(in_ptrs(w));
          if (p == 2) scr[0] = w;
          if (p == 3 && scr[1] != 0 && w == STORAGE_OUTPUT && !in_vars(scr[0])) begin
            if (var_cnt >= VAR_SLOTS) lflags |= FLAG_OVF;
            else begin
              var_tab[var_cnt] = scr[0];
              var_cnt++;
            end
          end
        end
      OP_STORE:
        if (ilen >= 3 && p == 1 && in_vars(w)) stores++;
      default: ;
    endcase
    bump_pos();
  endtask

  function automatic logic [2:0] learn_verdict();
    if (widx < 4 || (lflags & FLAG_BAD) != 0) return ST_BAD_HDR;
    if ((lflags & FLAG_MAL) != 0 || ipos != 0) return ST_MALFORM;
    if ((lflags & FLAG_OVF) != 0) return ST_OVERFLOW;
    if (ext_id == 0 || vec_id == 0 || var_cnt == 0 || !fn_seen) return ST_NOTHING;
    for (int k = 0; k < 4; k++)
      if (cids[k] == 0) begin
        cids[k] = bound;
        bound = bound + 1;
        minted[k] = 1'b1;
      end
    return ST_OK;
  endfunction

  task automatic put_constants();
    for (int k = 0; k < 4; k++) begin
      if (!minted[k]) continue;
      if (k < 2) begin
        put_word({16'd4, OP_CONSTANT}); put_word(flt_id); put_word(cids[k]);
        put_word(k == 0 ? 32'd0 : FLOAT_ONE);
      end else begin
        put_word({16'd7, OP_CONST_COMPOSITE}); put_word(vec_id); put_word(cids[k]);
        for (int j = 0; j < 4; j++) put_word(cids[k-2]);
      end
    end
  endtask

  task automatic put_clamp(input logic [31:0] value);
    logic [31:0] clamped, a, ca;
    clamped = free_id; free_id++;
    if (mode_alpha) begin
      a = free_id; free_id++;
      ca = free_id; free_id++;
      put_word({16'd5, OP_EXTRACT}); put_word(flt_id); put_word(a); put_word(value);
      put_word(ALPHA_LANE);
      put_word({16'd8, OP_EXT_INST}); put_word(flt_id); put_word(ca); put_word(ext_id);
      put_word(NCLAMP_INST); put_word(a); put_word(cids[0]); put_word(cids[1]);
      put_word({16'd6, OP_INSERT}); put_word(vec_id); put_word(clamped); put_word(ca);
      put_word(value); put_word(ALPHA_LANE);
    end else begin
      put_word({16'd8, OP_EXT_INST}); put_word(vec_id); put_word(clamped); put_word(ext_id);
      put_word(NCLAMP_INST); put_word(value); put_word(cids[2]); put_word(cids[3]);
    end
    put_word(held[0]); put_word(held[1]); put_word(clamped);
  endtask

  task automatic rewrite_one(input logic [31:0] w);
    bit learned;
    logic [15:0] len;
    learned = (lstat == ST_OK);
    if (widx == 0) begin
      held_n = 0; consts_done = 1'b0; free_id = bound; ipos = '0;
    end
    if (widx < 5) begin
      if (widx == 3 && learned) put_word(bound + stores * (mode_alpha ? 32'd3 : 32'd1));
      else put_word(w);
      return;
    end
    if (ipos == 0) begin
      len = w[31:16];
      ilen = (len == 0) ? 16'd1 : len;
      iop = w[15:0];
      if (learned && iop == OP_FUNCTION && !consts_done) begin
        put_constants();
        consts_done = 1'b1;
      end
      if (learned && iop == OP_STORE && ilen >= 3) begin
        held[0] = w; held_n = 1;
      end else put_word(w);
    end else if (held_n == 1 && ipos == 1) begin
      if (in_vars(w)) begin
        held[1] = w; held_n = 2;
      end else begin
        put_word(held[0]); put_word(w); held_n = 0;
      end
    end else if (held_n == 2 && ipos == 2) begin
      put_clamp(w);
      held_n = 0;
    end else put_word(w);
    bump_pos();
  endtask

  // Works out the result beats of one accepted input beat and queues them.
  task automatic predict_beat(input word_beat_t ib);
    step_beats.delete();
    if (ib.op == OPSEL_LEARN) begin
      if (widx == 0) begin
        ext_id = '0; flt_id = '0; vec_id = '0;
        for (int k = 0; k < 4; k++) cids[k] = '0;
        ptr_cnt = 0; var_cnt = 0; fn_seen = 1'b0; stores = '0; bound = '0;
        lstat = ST_DATA; lflags = '0; minted = '0; ipos = '0;
      end
      if (widx == 0 && ib.w != MAGIC_WORD) lflags |= FLAG_BAD;
      if (widx == 3) bound = ib.w;
      if (widx >= 5 && (lflags & (FLAG_BAD | FLAG_MAL)) == 0) learn_one(ib.w);
      if (ib.last) begin
        lstat = learn_verdict();
        put_word(32'd0, lstat);
      end
    end else begin
      rewrite_one(ib.w);
      if (ib.last) begin
        for (int i = 0; i < held_n; i++) put_word(held[i]);
        held_n = 0;
      end
    end
    if (ib.last) begin
      widx = '0; ipos = '0;
      if (step_beats.size() > 0) step_beats[step_beats.size()-1].mod_end = 1'b1;
    end else if (widx != 32'hFFFF_FFFF) widx++;
    if (step_beats.size() > 0) step_beats[step_beats.size()-1].run_last = 1'b1;
    foreach (step_beats[i]) expected_beats.insert(expected_beats.size(), step_beats[i]);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of beats with random gaps. Valid holds until acceptance.
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left = 0;
  bit drive_en = 1'b0;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        word_beat_t acc;
        acc.op = in_op; acc.w = in_word; acc.last = in_last;
        predict_beat(acc);
      end
      if (!in_valid || in_ready) begin
        if (drive_en && pending_words.size() > 0 && gap_left == 0) begin
          word_beat_t nb;
          nb = pending_words.pop_front();
          in_valid <= 1'b1;
          in_op <= nb.op; in_word <= nb.w; in_last <= nb.last;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall pattern, plus one long hold-off counted here.
  // ---------------------------------------------------------------------------
  int stall_mode = 0;
  int hold_cycles = 0;
  bit hold_req = 1'b0;

  always @(posedge clk) begin
    cycles++;
    if (hold_req && hold_cycles == 0) hold_cycles = 400;
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
      if (hold_cycles == 0) hold_req = 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compares each accepted result beat with the oldest expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        errors++;
        if (mismatches < 10)
          $display("unexpected result beat: word=%h status=%0d", out_word, out_status);
        mismatches++;
      end else begin
        result_beat_t e;
        e = expected_beats.pop_front();
        if (e.w !== out_word || e.run_last !== out_run_last ||
            e.mod_end !== out_module_end || e.st !== out_status) begin
          errors++;
          if (mismatches < 10)
            $display("mismatch: expected w=%h rl=%b me=%b st=%0d, got w=%h rl=%b me=%b st=%0d",
                     e.w, e.run_last, e.mod_end, e.st,
                     out_word, out_run_last, out_module_end, out_status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 400000) begin
      $display("** shader_output_clamp_rewriter_unit: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: shader modules built from plausible instructions with random ids.
  // ---------------------------------------------------------------------------
  logic [31:0] mod_words[$];

  task automatic add_words(input logic [31:0] w);
    mod_words.insert(mod_words.size(), w);
  endtask

  // Builds a module; kind 0 is well formed, others break it in some way.
  task automatic build_module(input int kind, input int n_store, input bit with_consts);
    logic [31:0] fid, vid, pid, eid, c0, c1;
    int n_var;
    mod_words.delete();
    fid = $urandom_range(2, 9); vid = fid + 1; pid = fid + 2; eid = 1;
    c0 = 40; c1 = 41;
    add_words(kind == 1 ? $urandom : MAGIC_WORD);
    add_words(32'h0001_0000); add_words(0); add_words(100); add_words(0);
    if ($urandom_range(0, 3) != 0 || kind == 0)
      begin
        add_words({16'd6, OP_EXT_IMPORT}); add_words(eid);
        add_words(GLSL_W0); add_words(GLSL_W1); add_words(GLSL_W2); add_words(0);
      end
    add_words({16'd3, OP_TYPE_FLOAT}); add_words(fid); add_words(32);
    add_words({16'd4, OP_TYPE_VECTOR}); add_words(vid); add_words(fid); add_words(4);
    add_words({16'd4, OP_TYPE_POINTER}); add_words(pid); add_words(STORAGE_OUTPUT);
    add_words(vid);
    if (kind == 3)
      for (int i = 0; i < 9; i++) begin
        add_words({16'd4, OP_TYPE_POINTER}); add_words(60 + i); add_words(STORAGE_OUTPUT);
        add_words(vid);
      end
    if (with_consts) begin
      add_words({16'd4, OP_CONSTANT}); add_words(fid); add_words(c0); add_words(0);
      add_words({16'd4, OP_CONSTANT}); add_words(fid); add_words(c1); add_words(FLOAT_ONE);
      add_words({16'd7, OP_CONST_COMPOSITE}); add_words(vid); add_words(42);
      for (int j = 0; j < 4; j++) add_words(c0);
    end
    n_var = (kind == 3) ? 17 : $urandom_range(1, 3);
    for (int i = 0; i < n_var; i++) begin
      add_words({16'd4, OP_VARIABLE}); add_words(pid); add_words(20 + i);
      add_words(STORAGE_OUTPUT);
    end
    if (kind == 2) add_words($urandom_range(0, 1) ? 32'h0000_0011 : {16'd5, 16'd17});
    if (kind != 4) begin
      add_words({16'd5, OP_FUNCTION}); add_words(1); add_words(50); add_words(0);
      add_words(51);
    end
    for (int i = 0; i < n_store; i++) begin
      add_words({16'd3, OP_STORE});
      add_words($urandom_range(0, 3) == 0 ? 32'd77 : 20 + $urandom_range(0, n_var - 1));
      add_words(70 + i);
      if ($urandom_range(0, 4) == 0) begin
        add_words({16'($urandom_range(1, 3)), 16'($urandom)});
        add_words($urandom);
      end
    end
    if (kind == 5) add_words({16'd3, OP_STORE});
    if (kind == 5) add_words(21);
  endtask

  task automatic queue_pass(input logic op);
    word_beat_t b;
    foreach (mod_words[i]) begin
      b.op = op; b.w = mod_words[i]; b.last = (i == mod_words.size() - 1);
      pending_words.insert(pending_words.size(), b);
    end
  endtask

  task automatic run_and_drain();
    drive_en = 1'b1;
    while (pending_words.size() > 0 || in_valid || expected_beats.size() > 0)
      @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_alpha_only_mode <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mode_alpha = m;
  endtask

  int sent;

  initial begin
    mode_alpha = 1'b0; widx = '0; ipos = '0; ilen = '0; iop = '0;
    ext_id = '0; flt_id = '0; vec_id = '0; ptr_cnt = 0; var_cnt = 0;
    fn_seen = 1'b0; stores = '0; bound = '0; lstat = '0; lflags = '0; minted = '0;
    held_n = 0; consts_done = 1'b0; free_id = '0;
    for (int k = 0; k < 4; k++) cids[k] = '0;
    for (int k = 0; k < 3; k++) scr[k] = '0;
    held[0] = '0; held[1] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: a short header and noise words with all bits toggling, then
    // one pair of a malformed module, which may hold a zero word count.
    begin
      word_beat_t b;
      b.op = 1'b0; b.w = MAGIC_WORD; b.last = 1'b0;
      pending_words.insert(pending_words.size(), b);
      b.w = 32'hFFFF_FFFF; b.last = 1'b1;
      pending_words.insert(pending_words.size(), b);
      b.op = 1'b1; b.w = 32'h0000_0000; b.last = 1'b0;
      pending_words.insert(pending_words.size(), b);
      b.w = 32'hFFFF_FFFF; b.last = 1'b1;
      pending_words.insert(pending_words.size(), b);
    end
    build_module(2, 2, 1'b0); queue_pass(1'b0); queue_pass(1'b1);
    sent = pending_words.size();
    run_and_drain();

    // Random pairs, with random mode settings and module shapes. The
    // closing pair below adds roughly another ninety beats.
    for (int r = 0; sent < 230; r++) begin
      int kind;
      if (r % 3 == 0) write_mode(1'($urandom_range(0, 1)));
      kind = ($urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 5);
      build_module(kind, $urandom_range(0, 4), 1'($urandom_range(0, 1)));
      queue_pass(1'b0);
      if ($urandom_range(0, 5) != 0) queue_pass(1'b1);
      sent += pending_words.size();
      // Long hold-off while the sender keeps offering one module.
      if (r == 2) hold_req = 1'b1;
      run_and_drain();
    end
    write_mode(1'b1);
    build_module(0, 3, 1'b0); queue_pass(1'b0); queue_pass(1'b1);
    run_and_drain();
    write_mode(1'b0);
    repeat (50) @(posedge clk);
    if (errors == 0 && expected_beats.size() == 0)
      $display("** shader_output_clamp_rewriter_unit: PASSED **");
    else
      $display("** shader_output_clamp_rewriter_unit: FAILED **");
    $finish;
  end
endmodule
